// ----- sv/sts_pkg.sv -----
// ---------------------------------------------------------------------------
// sts_pkg: shared types and constants of the styled text segmenter
// Command and status types between controller and datapath, byte constants
// and the format-code helpers used while scanning segment bytes.
// ---------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

    localparam int WINDOW_DEPTH_DEFAULT = 1024;
    localparam int MAX_RESULTS          = 16;
    localparam logic [9:0] MAX_BODY_RESET = 10'd1000;

    localparam logic [7:0] BYTE_SECTION_LEAD = 8'hC2;
    localparam logic [7:0] BYTE_SECTION_TAIL = 8'hA7;
    localparam logic [7:0] BYTE_NEWLINE      = 8'h0A;
    localparam logic [7:0] UTF8_CONT_MASK    = 8'hC0;
    localparam logic [7:0] UTF8_CONT_VALUE   = 8'h80;

    localparam logic [7:0] CODE_RESET     = "r";
    localparam logic [7:0] CODE_BOLD      = "l";
    localparam logic [7:0] CODE_ITALIC    = "o";
    localparam logic [7:0] CODE_UNDERLINE = "n";
    localparam logic [7:0] CODE_STRIKE    = "m";
    localparam logic [7:0] CODE_OBFUSCATE = "k";

    localparam int FLAG_BOLD      = 0;
    localparam int FLAG_ITALIC    = 1;
    localparam int FLAG_UNDERLINE = 2;
    localparam int FLAG_STRIKE    = 3;
    localparam int FLAG_OBFUSCATE = 4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EMPTY,
        S_CHECK,
        S_WALK_REQ,
        S_WALK_USE,
        S_SEC_USE0,
        S_SEC_USE1,
        S_ZFIX,
        S_NL_REQ,
        S_NL_USE,
        S_CUT_EMIT,
        S_SCAN_REQ,
        S_SCAN_USE,
        S_CONSUME,
        S_FINAL,
        S_FLUSH
    } sts_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CUT_START,
        OP_READ_POS,
        OP_POS_DEC,
        OP_READ_POS_M2,
        OP_READ_POS_M1,
        OP_POS_SUB2,
        OP_ZFIX,
        OP_READ_IDX_M1,
        OP_NL_HIT,
        OP_IDX_DEC,
        OP_PUSH_CUT,
        OP_READ_IDX,
        OP_SCAN_STEP,
        OP_CONSUME,
        OP_PUSH_FINAL,
        OP_MARK_END,
        OP_PUSH_EMPTY,
        OP_FLUSH
    } sts_op_t;

    typedef struct packed {
        sts_op_t op;
    } sts_cmd_t;

    typedef struct packed {
        logic cut_needed;
        logic limit_lt_n;
        logic pos_zero;
        logic rd_cont;
        logic rd_fmt_cut;
        logic rd_lead;
        logic rd_tail;
        logic rd_newline;
        logic idx_zero;
        logic idx_at_chunk;
        logic can_push;
        logic pend_valid;
        logic out_free;
        logic last;
        logic in_empty;
        logic final_seg;
    } sts_status_t;

    function automatic logic [7:0] to_lower_code(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_color_code(input logic [7:0] lc);
        return (lc >= "0" && lc <= "9") || (lc >= "a" && lc <= "g");
    endfunction

    function automatic logic is_format_code(input logic [7:0] c);
        logic [7:0] lc;
        lc = to_lower_code(c);
        return is_color_code(lc) || (lc >= "k" && lc <= "o") || lc == CODE_RESET;
    endfunction

endpackage

`default_nettype wire

// ----- sv/styled_text_segmenter.sv -----
// ---------------------------------------------------------------------------
// styled_text_segmenter: UTF-8 message segmenter with style prefix tracking
// Input words carry one message byte (or an empty-message mark); output words
// are segment descriptors that a downstream FIFO uses to copy the bytes.
// The input channel takes a word only in the idle state. A cut walks back
// over bytes for the character boundary and the newline search, then scans
// the segment bytes for the style; each byte read goes through the single
// RAM read port with its registered data. Up to 16 descriptors come from one
// word; the last is marked with run_last. Results pass through a held
// register and an output register, so a stalled receiver stops the block
// only when a new descriptor must move.
// The max_body_length register is written through its own valid/ready port,
// which is always ready. Reset empties the window, clears the style and
// loads a limit of 1000; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module styled_text_segmenter #(
    parameter int WINDOW_DEPTH = sts_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       last_byte,
    input  wire logic       empty_message,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [9:0] max_body_length,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [9:0]      segment_length,
    output logic            skip_newline,
    output logic [7:0]      prefix_color,
    output logic            prefix_bold,
    output logic            prefix_italic,
    output logic            prefix_underline,
    output logic            prefix_strike,
    output logic            prefix_obfuscated,
    output logic            message_end,
    output logic            run_last
);

    sts_pkg::sts_cmd_t    cmd;
    sts_pkg::sts_status_t status;

    assign cfg_ready = 1'b1;

    sts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sts_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .text_byte         (text_byte),
        .last_byte         (last_byte),
        .empty_message     (empty_message),
        .cfg_valid         (cfg_valid),
        .max_body_length   (max_body_length),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .segment_length    (segment_length),
        .skip_newline      (skip_newline),
        .prefix_color      (prefix_color),
        .prefix_bold       (prefix_bold),
        .prefix_italic     (prefix_italic),
        .prefix_underline  (prefix_underline),
        .prefix_strike     (prefix_strike),
        .prefix_obfuscated (prefix_obfuscated),
        .message_end       (message_end),
        .run_last          (run_last)
    );

endmodule

`default_nettype wire

// ----- sv/sts_ram.sv -----
// ---------------------------------------------------------------------------
// sts_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/sts_ctrl.sv -----
// ---------------------------------------------------------------------------
// sts_ctrl: segmenter controller
// Sequences accept, cut search, newline search, style scan and result
// hand-off by issuing one datapath command per cycle, or none while it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sts_pkg::sts_status_t status,
    output sts_pkg::sts_cmd_t        cmd
);

    sts_pkg::sts_state_t state_reg;
    sts_pkg::sts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = sts_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            sts_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = sts_pkg::OP_ACCEPT;
                    state_next = status.in_empty ? sts_pkg::S_EMPTY : sts_pkg::S_CHECK;
                end
            end
            sts_pkg::S_EMPTY:
            begin
                if (status.can_push)
                begin
                    cmd.op     = sts_pkg::OP_PUSH_EMPTY;
                    state_next = sts_pkg::S_FLUSH;
                end
            end
            sts_pkg::S_CHECK:
            begin
                priority if (status.cut_needed)
                begin
                    cmd.op     = sts_pkg::OP_CUT_START;
                    state_next = status.limit_lt_n ? sts_pkg::S_WALK_REQ : sts_pkg::S_ZFIX;
                end
                else if (status.last)
                begin
                    state_next = sts_pkg::S_FINAL;
                end
                else if (status.pend_valid)
                begin
                    state_next = sts_pkg::S_FLUSH;
                end
                else
                begin
                    state_next = sts_pkg::S_IDLE;
                end
            end
            sts_pkg::S_WALK_REQ:
            begin
                if (status.pos_zero)
                begin
                    state_next = sts_pkg::S_ZFIX;
                end
                else
                begin
                    cmd.op     = sts_pkg::OP_READ_POS;
                    state_next = sts_pkg::S_WALK_USE;
                end
            end
            sts_pkg::S_WALK_USE:
            begin
                // Back off continuation bytes, then off a split section code.
                priority if (status.rd_cont)
                begin
                    cmd.op     = sts_pkg::OP_POS_DEC;
                    state_next = sts_pkg::S_WALK_REQ;
                end
                else if (status.rd_fmt_cut)
                begin
                    cmd.op     = sts_pkg::OP_READ_POS_M2;
                    state_next = sts_pkg::S_SEC_USE0;
                end
                else
                begin
                    state_next = sts_pkg::S_ZFIX;
                end
            end
            sts_pkg::S_SEC_USE0:
            begin
                if (status.rd_lead)
                begin
                    cmd.op     = sts_pkg::OP_READ_POS_M1;
                    state_next = sts_pkg::S_SEC_USE1;
                end
                else
                begin
                    state_next = sts_pkg::S_ZFIX;
                end
            end
            sts_pkg::S_SEC_USE1:
            begin
                if (status.rd_tail)
                begin
                    cmd.op = sts_pkg::OP_POS_SUB2;
                end
                state_next = sts_pkg::S_ZFIX;
            end
            sts_pkg::S_ZFIX:
            begin
                cmd.op     = sts_pkg::OP_ZFIX;
                state_next = sts_pkg::S_NL_REQ;
            end
            sts_pkg::S_NL_REQ:
            begin
                if (status.idx_zero)
                begin
                    state_next = sts_pkg::S_CUT_EMIT;
                end
                else
                begin
                    cmd.op     = sts_pkg::OP_READ_IDX_M1;
                    state_next = sts_pkg::S_NL_USE;
                end
            end
            sts_pkg::S_NL_USE:
            begin
                if (status.rd_newline)
                begin
                    cmd.op     = sts_pkg::OP_NL_HIT;
                    state_next = sts_pkg::S_CUT_EMIT;
                end
                else
                begin
                    cmd.op     = sts_pkg::OP_IDX_DEC;
                    state_next = sts_pkg::S_NL_REQ;
                end
            end
            sts_pkg::S_CUT_EMIT:
            begin
                if (status.can_push)
                begin
                    cmd.op     = sts_pkg::OP_PUSH_CUT;
                    state_next = sts_pkg::S_SCAN_REQ;
                end
            end
            sts_pkg::S_SCAN_REQ:
            begin
                if (status.idx_at_chunk)
                begin
                    state_next = sts_pkg::S_CONSUME;
                end
                else
                begin
                    cmd.op     = sts_pkg::OP_READ_IDX;
                    state_next = sts_pkg::S_SCAN_USE;
                end
            end
            sts_pkg::S_SCAN_USE:
            begin
                cmd.op     = sts_pkg::OP_SCAN_STEP;
                state_next = sts_pkg::S_SCAN_REQ;
            end
            sts_pkg::S_CONSUME:
            begin
                cmd.op     = sts_pkg::OP_CONSUME;
                state_next = sts_pkg::S_CHECK;
            end
            sts_pkg::S_FINAL:
            begin
                if (status.final_seg)
                begin
                    if (status.can_push)
                    begin
                        cmd.op     = sts_pkg::OP_PUSH_FINAL;
                        state_next = sts_pkg::S_FLUSH;
                    end
                end
                else
                begin
                    cmd.op     = sts_pkg::OP_MARK_END;
                    state_next = sts_pkg::S_FLUSH;
                end
            end
            sts_pkg::S_FLUSH:
            begin
                priority if (!status.pend_valid)
                begin
                    state_next = sts_pkg::S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.op     = sts_pkg::OP_FLUSH;
                    state_next = sts_pkg::S_IDLE;
                end
                else
                begin
                    state_next = sts_pkg::S_FLUSH;
                end
            end
            default:
            begin
                state_next = sts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/sts_datapath.sv -----
// ---------------------------------------------------------------------------
// sts_datapath: segmenter window, style state and result registers
// Circular byte window in RAM, cut arithmetic, style tracking, a held result
// and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_datapath #(
    parameter int WINDOW_DEPTH = sts_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sts_pkg::sts_cmd_t    cmd,
    output sts_pkg::sts_status_t      status,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 last_byte,
    input  wire logic                 empty_message,
    input  wire logic                 cfg_valid,
    input  wire logic [9:0]           max_body_length,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [9:0]                segment_length,
    output logic                      skip_newline,
    output logic [7:0]                prefix_color,
    output logic                      prefix_bold,
    output logic                      prefix_italic,
    output logic                      prefix_underline,
    output logic                      prefix_strike,
    output logic                      prefix_obfuscated,
    output logic                      message_end,
    output logic                      run_last
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = AW + 1;
    localparam int LW = (CW > 10) ? CW : 10;
    localparam int SW = LW + 1;

    logic [AW-1:0] head_reg,  head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    color_reg, color_next;
    logic [4:0]    flags_reg, flags_next;
    logic [9:0]    maxlen_reg, maxlen_next;
    logic [4:0]    k_reg, k_next;
    logic          last_reg, last_next;
    logic [1:0]    scan_reg, scan_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;

    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] chunk_reg, chunk_next;
    logic          skip_reg, skip_next;
    logic [9:0]    pend_len_reg, pend_len_next;
    logic          pend_skip_reg, pend_skip_next;
    logic [7:0]    pend_color_reg, pend_color_next;
    logic [4:0]    pend_flags_reg, pend_flags_next;
    logic          pend_end_reg, pend_end_next;
    logic [9:0]    out_len_reg, out_len_next;
    logic          out_skip_reg, out_skip_next;
    logic [7:0]    out_color_reg, out_color_next;
    logic [4:0]    out_flags_reg, out_flags_next;
    logic          out_end_reg, out_end_next;
    logic          out_run_last_reg, out_run_last_next;

    logic [9:0]    lim;
    logic [2:0]    n_codes;
    logic [4:0]    pfx;
    logic [9:0]    cap;
    logic          limit_lt_n;
    logic [AW-1:0] cut_limit;
    logic          over;
    logic          k_ok;
    logic [AW-1:0] rd_off;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          we;
    logic [7:0]    rd_data;
    logic [7:0]    rd_lower;
    logic [AW-1:0] pos_fixed;
    logic          push_pend;
    logic          push_last;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(WINDOW_DEPTH))
        begin
            s = s - (AW+1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    sts_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (text_byte),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // Cut arithmetic on the current window and style.
    always_comb
    begin
        lim = (LW'(maxlen_reg) > LW'(WINDOW_DEPTH - 1)) ? 10'(WINDOW_DEPTH - 1) : maxlen_reg;
        n_codes = {2'b00, color_reg != 8'd0} + {2'b00, flags_reg[0]} + {2'b00, flags_reg[1]}
                + {2'b00, flags_reg[2]} + {2'b00, flags_reg[3]} + {2'b00, flags_reg[4]};
        pfx = {2'b00, n_codes} + {1'b0, n_codes, 1'b0};
        cap = ({5'd0, pfx} >= lim) ? 10'd0 : lim - {5'd0, pfx};
        limit_lt_n = LW'(cap) < LW'(count_reg);
        cut_limit  = limit_lt_n ? AW'(cap) : count_reg[AW-1:0];
        over = (SW'(pfx) + SW'(count_reg)) > SW'(lim);
        k_ok = k_reg < (last_reg ? 5'(sts_pkg::MAX_RESULTS - 1) : 5'(sts_pkg::MAX_RESULTS));
        pos_fixed = (pos_reg == '0) ? AW'(1) : pos_reg;
        rd_lower  = sts_pkg::to_lower_code(rd_data);
    end

    always_comb
    begin
        unique case (cmd.op)
            sts_pkg::OP_READ_POS:    rd_off = pos_reg;
            sts_pkg::OP_READ_POS_M2: rd_off = pos_reg - AW'(2);
            sts_pkg::OP_READ_POS_M1: rd_off = pos_reg - AW'(1);
            sts_pkg::OP_READ_IDX_M1: rd_off = idx_reg - AW'(1);
            sts_pkg::OP_READ_IDX:    rd_off = idx_reg;
            default:                 rd_off = '0;
        endcase
        raddr = wrap_add(head_reg, rd_off);
        waddr = wrap_add(head_reg, count_reg[AW-1:0]);
        we = (cmd.op == sts_pkg::OP_ACCEPT) && !empty_message
           && (count_reg < CW'(WINDOW_DEPTH));
    end

    always_comb
    begin
        status.cut_needed   = k_ok && (count_reg != '0) && over;
        status.limit_lt_n   = limit_lt_n;
        status.pos_zero     = pos_reg == '0;
        status.rd_cont      = (rd_data & sts_pkg::UTF8_CONT_MASK) == sts_pkg::UTF8_CONT_VALUE;
        status.rd_fmt_cut   = (pos_reg >= AW'(2)) && sts_pkg::is_format_code(rd_data);
        status.rd_lead      = rd_data == sts_pkg::BYTE_SECTION_LEAD;
        status.rd_tail      = rd_data == sts_pkg::BYTE_SECTION_TAIL;
        status.rd_newline   = rd_data == sts_pkg::BYTE_NEWLINE;
        status.idx_zero     = idx_reg == '0;
        status.idx_at_chunk = idx_reg == chunk_reg;
        status.can_push     = !pend_valid_reg || !out_valid_reg || out_ready;
        status.pend_valid   = pend_valid_reg;
        status.out_free     = !out_valid_reg || out_ready;
        status.last         = last_reg;
        status.in_empty     = empty_message;
        status.final_seg    = (count_reg != '0) || (k_reg == 5'd0);
    end

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        color_next      = color_reg;
        flags_next      = flags_reg;
        maxlen_next     = cfg_valid ? max_body_length : maxlen_reg;
        k_next          = k_reg;
        last_next       = last_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        chunk_next      = chunk_reg;
        skip_next       = skip_reg;
        pend_len_next   = pend_len_reg;
        pend_skip_next  = pend_skip_reg;
        pend_color_next = pend_color_reg;
        pend_flags_next = pend_flags_reg;
        pend_end_next   = pend_end_reg;
        push_pend       = 1'b0;
        push_last       = 1'b0;

        unique case (cmd.op)
            sts_pkg::OP_ACCEPT:
            begin
                last_next = last_byte;
                k_next    = 5'd0;
                if (we)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            sts_pkg::OP_CUT_START:
            begin
                pos_next = cut_limit;
            end
            sts_pkg::OP_POS_DEC:
            begin
                pos_next = pos_reg - AW'(1);
            end
            sts_pkg::OP_POS_SUB2:
            begin
                pos_next = pos_reg - AW'(2);
            end
            sts_pkg::OP_ZFIX:
            begin
                pos_next   = pos_fixed;
                idx_next   = pos_fixed;
                chunk_next = pos_fixed;
                skip_next  = 1'b0;
            end
            sts_pkg::OP_NL_HIT:
            begin
                chunk_next = idx_reg - AW'(1);
                skip_next  = 1'b1;
            end
            sts_pkg::OP_IDX_DEC:
            begin
                idx_next = idx_reg - AW'(1);
            end
            sts_pkg::OP_PUSH_CUT:
            begin
                // The descriptor carries the style in force before this segment.
                push_pend       = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_len_next   = 10'(chunk_reg);
                pend_skip_next  = skip_reg;
                pend_color_next = color_reg;
                pend_flags_next = flags_reg;
                pend_end_next   = 1'b0;
                idx_next        = '0;
                scan_next       = 2'd0;
            end
            sts_pkg::OP_SCAN_STEP:
            begin
                // Scan state: 1 after a section lead, 2 after a full section sign.
                if (scan_reg == 2'd1 && rd_data == sts_pkg::BYTE_SECTION_TAIL)
                begin
                    scan_next = 2'd2;
                end
                else
                begin
                    scan_next = (rd_data == sts_pkg::BYTE_SECTION_LEAD) ? 2'd1 : 2'd0;
                end
                if (scan_reg == 2'd2)
                begin
                    priority if (sts_pkg::is_color_code(rd_lower))
                    begin
                        color_next = rd_lower;
                        flags_next = 5'd0;
                    end
                    else if (rd_lower == sts_pkg::CODE_RESET)
                    begin
                        color_next = 8'd0;
                        flags_next = 5'd0;
                    end
                    else if (rd_lower == sts_pkg::CODE_BOLD)
                    begin
                        flags_next[sts_pkg::FLAG_BOLD] = 1'b1;
                    end
                    else if (rd_lower == sts_pkg::CODE_ITALIC)
                    begin
                        flags_next[sts_pkg::FLAG_ITALIC] = 1'b1;
                    end
                    else if (rd_lower == sts_pkg::CODE_UNDERLINE)
                    begin
                        flags_next[sts_pkg::FLAG_UNDERLINE] = 1'b1;
                    end
                    else if (rd_lower == sts_pkg::CODE_STRIKE)
                    begin
                        flags_next[sts_pkg::FLAG_STRIKE] = 1'b1;
                    end
                    else if (rd_lower == sts_pkg::CODE_OBFUSCATE)
                    begin
                        flags_next[sts_pkg::FLAG_OBFUSCATE] = 1'b1;
                    end
                    else
                    begin
                        flags_next = flags_reg;
                    end
                end
                idx_next = idx_reg + AW'(1);
            end
            sts_pkg::OP_CONSUME:
            begin
                head_next  = wrap_add(head_reg, chunk_reg + AW'(skip_reg));
                count_next = count_reg - CW'(chunk_reg) - CW'(skip_reg);
                k_next     = k_reg + 5'd1;
            end
            sts_pkg::OP_PUSH_FINAL:
            begin
                push_pend       = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_len_next   = 10'(count_reg);
                pend_skip_next  = 1'b0;
                pend_color_next = color_reg;
                pend_flags_next = flags_reg;
                pend_end_next   = 1'b1;
                count_next      = '0;
                color_next      = 8'd0;
                flags_next      = 5'd0;
            end
            sts_pkg::OP_MARK_END:
            begin
                pend_end_next = 1'b1;
                count_next    = '0;
                color_next    = 8'd0;
                flags_next    = 5'd0;
            end
            sts_pkg::OP_PUSH_EMPTY:
            begin
                push_pend       = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_len_next   = 10'd0;
                pend_skip_next  = 1'b0;
                pend_color_next = 8'd0;
                pend_flags_next = 5'd0;
                pend_end_next   = 1'b1;
                count_next      = '0;
                color_next      = 8'd0;
                flags_next      = 5'd0;
            end
            sts_pkg::OP_FLUSH:
            begin
                push_pend       = 1'b1;
                push_last       = 1'b1;
                pend_valid_next = 1'b0;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    // The held result moves to the output register once the next one exists,
    // or at the end of the item with the run-last mark.
    always_comb
    begin
        out_valid_next    = out_valid_reg && !out_ready;
        out_len_next      = out_len_reg;
        out_skip_next     = out_skip_reg;
        out_color_next    = out_color_reg;
        out_flags_next    = out_flags_reg;
        out_end_next      = out_end_reg;
        out_run_last_next = out_run_last_reg;
        if (push_pend)
        begin
            out_valid_next    = 1'b1;
            out_len_next      = pend_len_reg;
            out_skip_next     = pend_skip_reg;
            out_color_next    = pend_color_reg;
            out_flags_next    = pend_flags_reg;
            out_end_next      = pend_end_reg;
            out_run_last_next = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            color_reg      <= 8'd0;
            flags_reg      <= 5'd0;
            maxlen_reg     <= sts_pkg::MAX_BODY_RESET;
            k_reg          <= 5'd0;
            last_reg       <= 1'b0;
            scan_reg       <= 2'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            color_reg      <= color_next;
            flags_reg      <= flags_next;
            maxlen_reg     <= maxlen_next;
            k_reg          <= k_next;
            last_reg       <= last_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg          <= pos_next;
        idx_reg          <= idx_next;
        chunk_reg        <= chunk_next;
        skip_reg         <= skip_next;
        pend_len_reg     <= pend_len_next;
        pend_skip_reg    <= pend_skip_next;
        pend_color_reg   <= pend_color_next;
        pend_flags_reg   <= pend_flags_next;
        pend_end_reg     <= pend_end_next;
        out_len_reg      <= out_len_next;
        out_skip_reg     <= out_skip_next;
        out_color_reg    <= out_color_next;
        out_flags_reg    <= out_flags_next;
        out_end_reg      <= out_end_next;
        out_run_last_reg <= out_run_last_next;
    end

    assign out_valid         = out_valid_reg;
    assign segment_length    = out_len_reg;
    assign skip_newline      = out_skip_reg;
    assign prefix_color      = out_color_reg;
    assign prefix_bold       = out_flags_reg[sts_pkg::FLAG_BOLD];
    assign prefix_italic     = out_flags_reg[sts_pkg::FLAG_ITALIC];
    assign prefix_underline  = out_flags_reg[sts_pkg::FLAG_UNDERLINE];
    assign prefix_strike     = out_flags_reg[sts_pkg::FLAG_STRIKE];
    assign prefix_obfuscated = out_flags_reg[sts_pkg::FLAG_OBFUSCATE];
    assign message_end       = out_end_reg;
    assign run_last          = out_run_last_reg;

endmodule

`default_nettype wire
